// File: rtl/mtcp_pkg.sv
// shared types and constants for the midi track chunk parser
// used by mtcp_parse, mtcp_outq and midi_track_chunk_parser; no dependencies
`timescale 1ns / 1ps

package mtcp_pkg;

  // result kinds
  localparam logic [2:0] KIND_CHANNEL  = 3'd0;
  localparam logic [2:0] KIND_META     = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
  localparam logic [2:0] KIND_UNSUPP   = 3'd3;
  localparam logic [2:0] KIND_TRACK    = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  localparam logic [31:0] TRACK_TAG    = 32'h4D54_726B;  // "MTrk"
  localparam logic [7:0]  CONT_BIT     = 8'h80;
  localparam logic [7:0]  DATA_MASK    = 8'h7F;
  localparam logic [7:0]  META_STATUS  = 8'hFF;
  localparam logic [7:0]  SYSTEM_FIRST = 8'hF0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] delta_time;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [31:0] length;
    logic        last;
  } result_t;

  // one byte's output: an optional result, optionally followed by an error
  typedef struct packed {
    logic    has_item;
    logic    has_err;
    result_t item;
  } entry_t;

endpackage

// File: rtl/mtcp_parse.sv
// byte decoder of the track chunk parser: header scan, length, event decode
// holds all parser state; depends on mtcp_pkg
`timescale 1ns / 1ps

module mtcp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output mtcp_pkg::entry_t    res
);

  typedef enum logic [3:0] {
    PH_SCAN, PH_LEN, PH_DELTA, PH_DELTA_MORE, PH_STATUS,
    PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN, PH_META_PAY
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] header_shift, header_shift_next;
  logic [1:0]  header_pos, header_pos_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] delta_accum, delta_accum_next;
  logic [7:0]  running_status, running_status_next;
  logic [7:0]  first_data, first_data_next;
  logic [7:0]  meta_kind, meta_kind_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] payload_left, payload_left_next;
  logic        halted, halted_next;

  function automatic logic is_two_data(input logic [7:0] st);
    logic [3:0] t;
    t = st[7:4];
    return (t == 4'h8) || (t == 4'h9) || (t == 4'hA) || (t == 4'hB) || (t == 4'hE);
  endfunction

  function automatic logic is_one_data(input logic [7:0] st);
    logic [3:0] t;
    t = st[7:4];
    return (t == 4'hC) || (t == 4'hD);
  endfunction

  always_comb begin
    logic [31:0] shift_new;
    logic [31:0] len_new;
    logic [31:0] rem_dec;
    logic        meta_fail;
    phase_next          = phase;
    header_shift_next   = header_shift;
    header_pos_next     = header_pos;
    remaining_next      = remaining;
    delta_accum_next    = delta_accum;
    running_status_next = running_status;
    first_data_next     = first_data;
    meta_kind_next      = meta_kind;
    length_accum_next   = length_accum;
    payload_left_next   = payload_left;
    halted_next         = halted;
    res                 = '0;
    shift_new = {header_shift[23:0], byte_in};
    len_new   = {length_accum[24:0], byte_in[6:0]};
    rem_dec   = remaining - 32'd1;
    meta_fail = 1'b0;

    if (step && !halted) begin
      if (phase == PH_SCAN || phase == PH_LEN) begin
        if (header_pos != 2'd3) begin
          header_shift_next = shift_new;
          header_pos_next   = header_pos + 2'd1;
        end else begin
          header_pos_next   = '0;
          header_shift_next = '0;
          if (phase == PH_SCAN) begin
            if (shift_new == mtcp_pkg::TRACK_TAG) phase_next = PH_LEN;
          end else begin
            remaining_next = shift_new;
            if (shift_new == '0) begin
              halted_next = 1'b1;
              res.has_err = 1'b1;
            end else begin
              running_status_next = '0;
              phase_next          = PH_DELTA;
              delta_accum_next    = '0;
              res.has_item        = 1'b1;
              res.item.kind       = mtcp_pkg::KIND_TRACK;
              res.item.length     = shift_new;
            end
          end
        end
      end else if (remaining == '0) begin
        halted_next = 1'b1;
        res.has_err = 1'b1;
      end else begin
        remaining_next = rem_dec;
        unique case (phase)
          PH_DELTA, PH_DELTA_MORE: begin
            delta_accum_next = {delta_accum[24:0], byte_in[6:0]};
            phase_next = ((byte_in & mtcp_pkg::CONT_BIT) != '0) ? PH_DELTA_MORE : PH_STATUS;
          end
          PH_STATUS: begin
            if ((byte_in & mtcp_pkg::CONT_BIT) != '0) begin
              if (byte_in == mtcp_pkg::META_STATUS) begin
                running_status_next = '0;
                phase_next          = PH_META_TYPE;
              end else if (byte_in < mtcp_pkg::SYSTEM_FIRST) begin
                running_status_next = byte_in;
                phase_next          = PH_DATA1;
              end else begin
                running_status_next = '0;
                res.has_item        = 1'b1;
                res.item.kind       = mtcp_pkg::KIND_UNSUPP;
                res.item.delta_time = delta_accum;
                res.item.status     = byte_in;
                phase_next          = PH_DELTA;
                delta_accum_next    = '0;
              end
            end else if (is_two_data(running_status)) begin
              first_data_next = byte_in;
              phase_next      = PH_DATA2;
            end else if (is_one_data(running_status)) begin
              res.has_item        = 1'b1;
              res.item.kind       = mtcp_pkg::KIND_CHANNEL;
              res.item.delta_time = delta_accum;
              res.item.status     = running_status;
              res.item.data1      = byte_in;
              phase_next          = PH_DELTA;
              delta_accum_next    = '0;
            end else begin
              // stray data byte: report it, then reuse it as a delta time
              res.has_item        = 1'b1;
              res.item.kind       = mtcp_pkg::KIND_UNSUPP;
              res.item.delta_time = delta_accum;
              res.item.status     = running_status;
              delta_accum_next    = {24'd0, byte_in};
              phase_next          = PH_STATUS;
            end
          end
          PH_DATA1: begin
            if (is_two_data(running_status)) begin
              first_data_next = byte_in;
              phase_next      = PH_DATA2;
            end else begin
              res.has_item        = 1'b1;
              res.item.kind       = mtcp_pkg::KIND_CHANNEL;
              res.item.delta_time = delta_accum;
              res.item.status     = running_status;
              res.item.data1      = byte_in;
              phase_next          = PH_DELTA;
              delta_accum_next    = '0;
            end
          end
          PH_DATA2: begin
            res.has_item        = 1'b1;
            res.item.kind       = mtcp_pkg::KIND_CHANNEL;
            res.item.delta_time = delta_accum;
            res.item.status     = running_status;
            res.item.data1      = first_data;
            res.item.data2      = byte_in;
            phase_next          = PH_DELTA;
            delta_accum_next    = '0;
          end
          PH_META_TYPE: begin
            meta_kind_next    = byte_in;
            length_accum_next = '0;
            phase_next        = PH_META_LEN;
          end
          PH_META_LEN: begin
            length_accum_next = len_new;
            if ((byte_in & mtcp_pkg::CONT_BIT) == '0) begin
              if (len_new > rem_dec) begin
                meta_fail   = 1'b1;
                halted_next = 1'b1;
                res.has_err = 1'b1;
              end else begin
                res.has_item        = 1'b1;
                res.item.kind       = mtcp_pkg::KIND_META;
                res.item.delta_time = delta_accum;
                res.item.status     = mtcp_pkg::META_STATUS;
                res.item.data1      = meta_kind;
                res.item.length     = len_new;
                res.item.last       = (len_new == '0);
                if (len_new == '0) begin
                  phase_next       = PH_DELTA;
                  delta_accum_next = '0;
                end else begin
                  payload_left_next = len_new;
                  phase_next        = PH_META_PAY;
                end
              end
            end
          end
          PH_META_PAY: begin
            res.has_item        = 1'b1;
            res.item.kind       = mtcp_pkg::KIND_PAYLOAD;
            res.item.delta_time = delta_accum;
            res.item.status     = mtcp_pkg::META_STATUS;
            res.item.data1      = byte_in;
            res.item.length     = length_accum;
            res.item.last       = (payload_left == 32'd1);
            if (payload_left <= 32'd1) begin
              payload_left_next = '0;
              phase_next        = PH_DELTA;
              delta_accum_next  = '0;
            end else begin
              payload_left_next = payload_left - 32'd1;
            end
          end
          default: begin
            phase_next       = PH_DELTA;
            delta_accum_next = '0;
          end
        endcase
        // body used up: clean end only at an event boundary
        if (!meta_fail && rem_dec == '0) begin
          if (phase_next == PH_DELTA) begin
            phase_next        = PH_SCAN;
            header_pos_next   = '0;
            header_shift_next = '0;
          end else begin
            halted_next = 1'b1;
            res.has_err = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      header_shift   <= '0;
      header_pos     <= '0;
      remaining      <= '0;
      delta_accum    <= '0;
      running_status <= '0;
      first_data     <= '0;
      meta_kind      <= '0;
      length_accum   <= '0;
      payload_left   <= '0;
      halted         <= 1'b0;
    end else begin
      phase          <= phase_next;
      header_shift   <= header_shift_next;
      header_pos     <= header_pos_next;
      remaining      <= remaining_next;
      delta_accum    <= delta_accum_next;
      running_status <= running_status_next;
      first_data     <= first_data_next;
      meta_kind      <= meta_kind_next;
      length_accum   <= length_accum_next;
      payload_left   <= payload_left_next;
      halted         <= halted_next;
    end
  end

endmodule

// File: rtl/mtcp_outq.sv
// two-entry result queue; an entry holding a result and an error is sent as two requests
// depends on mtcp_pkg
`timescale 1ns / 1ps

module mtcp_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mtcp_pkg::entry_t  push_entry,
  output logic              full,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [87:0]       m_tdata,   // delta_time, status, data1, data2, length
  output logic [2:0]        m_tuser,   // kind
  output logic              m_tlast    // last
);

  mtcp_pkg::entry_t  q [2];
  logic [1:0]        cnt;
  logic              err_turn;     // head's result already sent, error pending
  logic              send_err;
  logic              pop;
  logic [1:0]        wr_pos;
  mtcp_pkg::result_t cur;

  assign full     = (cnt == 2'd2);
  assign m_tvalid = (cnt != 2'd0);
  assign send_err = err_turn || !q[0].has_item;
  assign pop      = m_tvalid && m_tready && (send_err || !q[0].has_err);
  assign wr_pos   = cnt - {1'b0, pop};

  always_comb begin
    cur = q[0].item;
    if (send_err) begin
      cur      = '0;
      cur.kind = mtcp_pkg::KIND_ERROR;
    end
  end

  assign m_tdata = {cur.length, cur.data2, cur.data1, cur.status, cur.delta_time};
  assign m_tuser = cur.kind;
  assign m_tlast = cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      err_turn <= 1'b0;
    end else begin
      cnt <= cnt - {1'b0, pop} + {1'b0, push};
      if (pop) begin
        err_turn <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        err_turn <= 1'b1;
      end
    end
    // head slot: a new entry landing there wins over the shift from slot 1
    if (push && wr_pos == 2'd0) begin
      q[0] <= push_entry;
    end else if (pop) begin
      q[0] <= q[1];
    end
    if (push && wr_pos == 2'd1) begin
      q[1] <= push_entry;
    end
  end

endmodule

// File: rtl/midi_track_chunk_parser.sv
// top level of the midi track chunk parser: input register, decoder, result queue
// depends on mtcp_pkg, mtcp_parse, mtcp_outq
`timescale 1ns / 1ps

//  channel | dir | signals                    | contents
//  s       | in  | s_tvalid s_tready s_tdata  | tdata[7:0] in_byte
//  m       | out | m_tvalid m_tready m_tdata  | tdata: delta_time, status, data1, data2,
//          |     | m_tuser m_tlast            |   length; tuser kind; tlast last
//
// one byte is taken per cycle while the result queue has room; a byte's first result
// is offered on the m side after its request is accepted and it has passed the input
// register and been decoded into the result queue.
// a byte that yields a result followed by an error needs two m requests; the
// block halts after any error and then drops every further byte until rst.
// rst (synchronous) returns the parser to scanning for a track header.
// the input register stalls only while the two-entry result queue is full.

module midi_track_chunk_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // delta_time[31:0], status[39:32], data1[47:40],
                                 // data2[55:48], length[87:56]
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);

  // input register
  logic             byte_vld;
  logic [7:0]       byte_r;
  logic             q_full;
  logic             step;
  mtcp_pkg::entry_t res;

  // decode the held byte whenever the queue has room for its entry
  assign step     = byte_vld && !q_full;
  assign s_tready = !byte_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (s_tready) begin
      byte_vld <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      byte_r <= s_tdata;
    end
  end

  mtcp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (byte_r),
    .res     (res)
  );

  // only bytes that produce something occupy a queue slot
  mtcp_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (step && (res.has_item || res.has_err)),
    .push_entry (res),
    .full       (q_full),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
